// File: sv/ikf_pkg.sv
// Package with the shared types and constants of the INI section key finder.
`timescale 1ns / 1ps
`default_nettype none
package ikf_pkg;

	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
	localparam int READY_LIMIT = FIFO_DEPTH - 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;

	typedef enum logic [1:0] {
		REG_SECTION_NAME = 2'd0,
		REG_SECTION_LEN  = 2'd1,
		REG_KEY_NAME     = 2'd2,
		REG_KEY_LEN      = 2'd3
	} ikf_reg_t;

	typedef enum logic [2:0] {
		MODE_LINE,
		MODE_SKIP,
		MODE_SECT,
		MODE_KEY,
		MODE_VALUE,
		MODE_DONE
	} ikf_mode_t;

	typedef struct packed {
		logic [63:0] section_name;
		logic [3:0]  section_len;
		logic [63:0] key_name;
		logic [3:0]  key_len;
	} ikf_cfg_t;

	typedef struct packed {
		logic       out_kind;
		logic [7:0] value_char;
		logic       found;
		logic       last_of_run;
	} ikf_result_t;

endpackage
`default_nettype wire

// File: sv/ikf_text_if.sv
// Stream interface that carries text words into the key finder.
`timescale 1ns / 1ps
`default_nettype none
interface ikf_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

// File: sv/ikf_result_if.sv
// Stream interface that carries result words out of the key finder.
`timescale 1ns / 1ps
`default_nettype none
interface ikf_result_if;
	logic       valid;
	logic       ready;
	logic       out_kind;
	logic [7:0] value_char;
	logic       found;
	logic       last_of_run;

	modport source (output valid, output out_kind, output value_char, output found,
		output last_of_run, input ready);
	modport sink (input valid, input out_kind, input value_char, input found,
		input last_of_run, output ready);
endinterface
`default_nettype wire

// File: sv/ikf_parser.sv
// Input register and per-byte parse logic that produces up to two result words.
`timescale 1ns / 1ps
`default_nettype none
module ikf_parser #(
	parameter int NAME_CHARS      = 8,
	parameter int MAX_VALUE_CHARS = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ikf_pkg::ikf_cfg_t    cfg,
	input  wire logic                 in_accept,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 in_eot,
	output logic [1:0]                push_n,
	output ikf_pkg::ikf_result_t      res [2]
);
	import ikf_pkg::*;

	localparam int NCW = $clog2(NAME_CHARS + 1);
	localparam int VCW = $clog2(MAX_VALUE_CHARS + 1);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           eot_s1;

	ikf_mode_t      mode_q, mode_n;
	logic           ins_q, ins_n;
	logic [NCW-1:0] nc_q, nc_n;
	logic           nm_q, nm_n;
	logic [VCW-1:0] vc_q, vc_n;

	logic           do_key;
	logic           do_name;
	logic           name_is_sect;
	logic [63:0]    want;
	logic [7:0]     exp_byte;
	logic           is_nl;
	logic [1:0]     n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= in_byte;
			eot_s1  <= in_eot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINE;
			ins_q  <= 1'b0;
			nc_q   <= '0;
			nm_q   <= 1'b1;
			vc_q   <= '0;
		end else if (valid_s1) begin
			mode_q <= mode_n;
			ins_q  <= ins_n;
			nc_q   <= nc_n;
			nm_q   <= nm_n;
			vc_q   <= vc_n;
		end
	end

	always_comb begin
		mode_n       = mode_q;
		ins_n        = ins_q;
		nc_n         = nc_q;
		nm_n         = nm_q;
		vc_n         = vc_q;
		do_key       = 1'b0;
		do_name      = 1'b0;
		name_is_sect = 1'b0;
		want         = '0;
		exp_byte     = '0;
		n            = 2'd0;
		res[0]       = '0;
		res[1]       = '0;
		is_nl        = (byte_s1 == CH_LF) || (byte_s1 == CH_CR);

		if (mode_q != MODE_DONE) begin
			if (byte_s1 == CH_NUL) begin
				res[n[0]] = '{out_kind: 1'b1, value_char: 8'd0,
					found: (mode_q == MODE_VALUE), last_of_run: 1'b0};
				n = n + 2'd1;
				mode_n = MODE_DONE;
			end else begin
				unique case (mode_q)
					MODE_LINE: begin
						if (byte_s1 == CH_SPACE || byte_s1 == CH_TAB || is_nl) begin
							mode_n = MODE_LINE;
						end else if (byte_s1 == CH_SEMI || byte_s1 == CH_HASH) begin
							mode_n = MODE_SKIP;
						end else if (byte_s1 == CH_LBRK) begin
							mode_n = MODE_SECT;
							nc_n   = '0;
							nm_n   = 1'b1;
						end else if (!ins_q) begin
							mode_n = MODE_SKIP;
						end else begin
							mode_n = MODE_KEY;
							nc_n   = '0;
							nm_n   = 1'b1;
							do_key = 1'b1;
						end
					end
					MODE_SKIP: begin
						if (is_nl) begin
							mode_n = MODE_LINE;
						end
					end
					MODE_SECT: begin
						if (byte_s1 == CH_RBRK) begin
							if (ins_q) begin
								res[n[0]] = '{out_kind: 1'b1, value_char: 8'd0,
									found: 1'b0, last_of_run: 1'b0};
								n = n + 2'd1;
								mode_n = MODE_DONE;
							end else begin
								if (nm_q && (32'(cfg.section_len) <= NAME_CHARS) &&
										(32'(nc_q) == 32'(cfg.section_len))) begin
									ins_n = 1'b1;
								end
								mode_n = MODE_SKIP;
							end
						end else if (is_nl) begin
							mode_n = MODE_LINE;
						end else begin
							do_name      = 1'b1;
							name_is_sect = 1'b1;
						end
					end
					MODE_KEY: begin
						do_key = 1'b1;
					end
					MODE_VALUE: begin
						if (is_nl) begin
							res[n[0]] = '{out_kind: 1'b1, value_char: 8'd0,
								found: 1'b1, last_of_run: 1'b0};
							n = n + 2'd1;
							mode_n = MODE_DONE;
						end else begin
							res[n[0]] = '{out_kind: 1'b0, value_char: byte_s1,
								found: 1'b0, last_of_run: 1'b0};
							n = n + 2'd1;
							if (32'(vc_q) == MAX_VALUE_CHARS - 1) begin
								res[n[0]] = '{out_kind: 1'b1, value_char: 8'd0,
									found: 1'b1, last_of_run: 1'b0};
								n = n + 2'd1;
								mode_n = MODE_DONE;
							end else begin
								vc_n = vc_q + 1'b1;
							end
						end
					end
					default: begin
						mode_n = mode_q;
					end
				endcase

				if (do_key) begin
					if (is_nl) begin
						mode_n = MODE_LINE;
					end else if (byte_s1 == CH_EQ) begin
						if (nm_n && (32'(cfg.key_len) <= NAME_CHARS) &&
								(32'(nc_n) == 32'(cfg.key_len))) begin
							mode_n = MODE_VALUE;
							vc_n   = '0;
						end else begin
							mode_n = MODE_SKIP;
						end
					end else begin
						do_name = 1'b1;
					end
				end

				if (do_name) begin
					want = name_is_sect ? cfg.section_name : cfg.key_name;
					for (int i = 0; i < 8; i++) begin
						if (32'(nc_n) == i) begin
							exp_byte = want[8*i +: 8];
						end
					end
					if (32'(nc_n) < NAME_CHARS) begin
						if (byte_s1 != exp_byte) begin
							nm_n = 1'b0;
						end
						nc_n = nc_n + 1'b1;
					end else begin
						nm_n = 1'b0;
					end
				end
			end

			if (eot_s1 && (mode_n != MODE_DONE)) begin
				res[n[0]] = '{out_kind: 1'b1, value_char: 8'd0,
					found: (mode_n == MODE_VALUE), last_of_run: 1'b0};
				n = n + 2'd1;
				mode_n = MODE_DONE;
			end
		end

		if (eot_s1) begin
			mode_n = MODE_LINE;
			ins_n  = 1'b0;
			nc_n   = '0;
			nm_n   = 1'b1;
			vc_n   = '0;
		end

		if (n == 2'd1) begin
			res[0].last_of_run = 1'b1;
		end else if (n == 2'd2) begin
			res[1].last_of_run = 1'b1;
		end

		push_n = valid_s1 ? n : 2'd0;
	end

endmodule
`default_nettype wire

// File: sv/ikf_fifo.sv
// Result queue that takes up to two words per cycle and gives one per cycle on each pop.
`timescale 1ns / 1ps
`default_nettype none
module ikf_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [1:0]                    push_n,
	input  wire ikf_pkg::ikf_result_t          din [2],
	input  wire logic                          pop,
	output ikf_pkg::ikf_result_t               dout,
	output logic                               not_empty,
	output logic [ikf_pkg::FIFO_CW-1:0]        count
);
	import ikf_pkg::*;

	ikf_result_t        mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= din[0];
		end
		if (push_n == 2'd2) begin
			mem_q[FIFO_AW'(wr_ptr_q + 1'b1)] <= din[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= FIFO_AW'(wr_ptr_q + push_n);
			rd_ptr_q <= FIFO_AW'(rd_ptr_q + pop);
			count_q  <= FIFO_CW'(count_q + push_n - pop);
		end
	end

	assign dout      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule
`default_nettype wire

// File: sv/ini_section_key_finder.sv
// Top level of the INI section key finder: configuration, parser and result queue.
// A result word passes through the input register and the result queue on its way
// to the result port. One text word is taken per cycle while ready is high; a word
// that causes two results puts both into the eight-entry result queue.
// Ready drops while the queue holds more than four words.
// Reset clears the parse state, the queue and all configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module ini_section_key_finder #(
	parameter int NAME_CHARS      = 8,
	parameter int MAX_VALUE_CHARS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	ikf_text_if.sink         text,
	ikf_result_if.source     result
);
	import ikf_pkg::*;

	ikf_cfg_t           cfg_q;
	logic               in_accept;
	logic [1:0]         push_n;
	ikf_result_t        res [2];
	ikf_result_t        head;
	logic               not_empty;
	logic [FIFO_CW-1:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (ikf_reg_t'(cfg_index))
				REG_SECTION_NAME: cfg_q.section_name <= cfg_data;
				REG_SECTION_LEN:  cfg_q.section_len  <= cfg_data[3:0];
				REG_KEY_NAME:     cfg_q.key_name     <= cfg_data;
				REG_KEY_LEN:      cfg_q.key_len      <= cfg_data[3:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	assign text.ready = (32'(count) <= READY_LIMIT);
	assign in_accept  = text.valid && text.ready;

	ikf_parser #(
		.NAME_CHARS      (NAME_CHARS),
		.MAX_VALUE_CHARS (MAX_VALUE_CHARS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_accept (in_accept),
		.in_byte   (text.text_byte),
		.in_eot    (text.end_of_text),
		.push_n    (push_n),
		.res       (res)
	);

	ikf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.din       (res),
		.pop       (result.valid && result.ready),
		.dout      (head),
		.not_empty (not_empty),
		.count     (count)
	);

	assign result.valid       = not_empty;
	assign result.out_kind    = head.out_kind;
	assign result.value_char  = head.value_char;
	assign result.found       = head.found;
	assign result.last_of_run = head.last_of_run;

endmodule
`default_nettype wire

// File: sv/ikf_checker.sv
// Port checker for the key finder and the bind that attaches it to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ikf_port_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       out_kind,
	input wire logic [7:0] value_char,
	input wire logic       found,
	input wire logic       last_of_run
);

	// A stalled result word keeps its place, its kind and its value byte.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_char) && $stable(out_kind))
		else $error("result word changed while stalled");

	// A word that is not the last of its run is a value byte followed at once by a finish.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && out_kind)
		else $error("value byte of a pair not followed by finish word");

	// A finish word always closes the run of its text word.
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind |-> last_of_run && (value_char == 8'd0))
		else $error("finish word malformed");

	// A value byte is never a zero byte and never reports found.
	a_value_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> (value_char != 8'd0) && !found)
		else $error("value word malformed");

endmodule

bind ini_section_key_finder ikf_port_checker u_ikf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_kind    (result.out_kind),
	.value_char  (result.value_char),
	.found       (result.found),
	.last_of_run (result.last_of_run)
);
`default_nettype wire

// File: sim/ikf_checker.sv
// Checker that predicts the result words of the INI key finder and compares them.
`timescale 1ns / 1ps
module ikf_checker
	import ikf_pkg::*;
#(
	parameter int NAME_CHARS      = 8,
	parameter int MAX_VALUE_CHARS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	ikf_text_if         text,
	ikf_result_if       result,
	output int          fail_count,
	output int          pending
);

	ikf_cfg_t    cfg;
	ikf_mode_t   mode;
	logic        in_section;
	int          name_len;
	logic        name_same;
	int          value_len;
	ikf_result_t due_words[$];
	ikf_result_t oldest;

	function automatic void restart_search();
		mode = MODE_LINE;
		in_section = 1'b0;
		name_len = 0;
		name_same = 1'b1;
		value_len = 0;
	endfunction

	function automatic void push_word(logic kind, logic [7:0] ch, logic fnd);
		ikf_result_t w;
		w.out_kind = kind;
		w.value_char = ch;
		w.found = fnd;
		w.last_of_run = 1'b0;
		due_words.push_back(w);
	endfunction

	function automatic void end_search(logic fnd);
		push_word(1'b1, 8'h00, fnd);
		mode = MODE_DONE;
	endfunction

	function automatic void take_name_char(logic [7:0] c, logic [63:0] want);
		if (name_len < NAME_CHARS) begin
			if (c != want[8*name_len +: 8])
				name_same = 1'b0;
			name_len++;
		end else begin
			name_same = 1'b0;
		end
	endfunction

	function automatic logic name_hit(logic [3:0] len);
		return name_same && len <= NAME_CHARS && name_len == len;
	endfunction

	function automatic logic is_eol(logic [7:0] c);
		return c == CH_LF || c == CH_CR;
	endfunction

	function automatic void key_char(logic [7:0] c);
		if (is_eol(c)) begin
			mode = MODE_LINE;
		end else if (c == CH_EQ) begin
			if (name_hit(cfg.key_len)) begin
				mode = MODE_VALUE;
				value_len = 0;
			end else begin
				mode = MODE_SKIP;
			end
		end else begin
			take_name_char(c, cfg.key_name);
		end
	endfunction

	function automatic void parse_char(logic [7:0] c);
		case (mode)
			MODE_LINE: begin
				if (!(c == CH_SPACE || c == CH_TAB || is_eol(c))) begin
					if (c == CH_SEMI || c == CH_HASH) begin
						mode = MODE_SKIP;
					end else if (c == CH_LBRK) begin
						mode = MODE_SECT;
						name_len = 0;
						name_same = 1'b1;
					end else if (!in_section) begin
						mode = MODE_SKIP;
					end else begin
						mode = MODE_KEY;
						name_len = 0;
						name_same = 1'b1;
						key_char(c);
					end
				end
			end
			MODE_SKIP: begin
				if (is_eol(c))
					mode = MODE_LINE;
			end
			MODE_SECT: begin
				if (c == CH_RBRK) begin
					if (in_section) begin
						end_search(1'b0);
					end else begin
						if (name_hit(cfg.section_len))
							in_section = 1'b1;
						mode = MODE_SKIP;
					end
				end else if (is_eol(c)) begin
					mode = MODE_LINE;
				end else begin
					take_name_char(c, cfg.section_name);
				end
			end
			MODE_KEY: begin
				key_char(c);
			end
			MODE_VALUE: begin
				if (is_eol(c)) begin
					end_search(1'b1);
				end else begin
					push_word(1'b0, c, 1'b0);
					value_len++;
					if (value_len >= MAX_VALUE_CHARS)
						end_search(1'b1);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void predict_word(logic [7:0] c, logic eot);
		int queued;
		ikf_result_t w;
		queued = due_words.size();
		if (mode != MODE_DONE) begin
			if (c == CH_NUL)
				end_search(mode == MODE_VALUE);
			else
				parse_char(c);
			if (eot && mode != MODE_DONE)
				end_search(mode == MODE_VALUE);
		end
		if (eot)
			restart_search();
		if (due_words.size() > queued) begin
			w = due_words.pop_back();
			w.last_of_run = 1'b1;
			due_words.push_back(w);
		end
	endfunction

	function automatic void check_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '0;
			restart_search();
			due_words.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (due_words.size() == 0) begin
					$display("%0t: word with nothing expected: kind %0d char %0h found %0d last %0d",
						$time, result.out_kind, result.value_char, result.found,
						result.last_of_run);
					fail_count++;
				end else begin
					oldest = due_words.pop_front();
					check_field("out_kind", oldest.out_kind, result.out_kind);
					check_field("value_char", oldest.value_char, result.value_char);
					check_field("found", oldest.found, result.found);
					check_field("last_of_run", oldest.last_of_run, result.last_of_run);
				end
			end
			if (text.valid && text.ready)
				predict_word(text.text_byte, text.end_of_text);
			if (cfg_we) begin
				case (ikf_reg_t'(cfg_index))
					REG_SECTION_NAME: cfg.section_name = cfg_data;
					REG_SECTION_LEN:  cfg.section_len = cfg_data[3:0];
					REG_KEY_NAME:     cfg.key_name = cfg_data;
					REG_KEY_LEN:      cfg.key_len = cfg_data[3:0];
					default: begin
					end
				endcase
			end
			pending = due_words.size();
		end
	end

endmodule

// File: sim/tb_top.sv
// Testbench top that feeds INI texts into the key finder and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
	import ikf_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_word_t;

	localparam int ITEM_GOAL = 1800;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          pending;
	int          items_sent;
	bit          hold_results;
	logic [63:0] sec_name;
	logic [63:0] key_name;
	int          sec_n;
	int          key_n;
	text_word_t  words[$];

	ikf_text_if   text_ch();
	ikf_result_if result_ch();

	ini_section_key_finder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text      (text_ch),
		.result    (result_ch)
	);

	ikf_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.text       (text_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// The receiver changes its stall pattern now and then and holds off
	// for a long stretch whenever the stimulus asks for it.
	initial begin
		int mode_left;
		int pat;
		int hold;
		mode_left = 0;
		pat = 0;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				hold_results = 1'b0;
				hold = 90;
			end
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					pat = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (pat)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= ($urandom_range(0, 3) != 0);
					2: result_ch.ready <= ($urandom_range(0, 1) == 1);
					default: result_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic void put_byte(logic [7:0] c);
		text_word_t w;
		w.ch = c;
		w.eot = 1'b0;
		words.push_back(w);
	endfunction

	function automatic void put_text(string s);
		foreach (s[i])
			put_byte(s[i]);
	endfunction

	function automatic void close_text();
		text_word_t w;
		w = words.pop_back();
		w.eot = 1'b1;
		words.push_back(w);
	endfunction

	function automatic logic [7:0] name_char();
		string pool;
		logic [7:0] c;
		pool = "abkxAB09_-.";
		if ($urandom_range(0, 3) != 0)
			return pool[$urandom_range(0, pool.len() - 1)];
		do
			c = 8'($urandom_range(33, 255));
		while (c == CH_EQ || c == CH_RBRK);
		return c;
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CH_LF || c == CH_CR);
		return c;
	endfunction

	function automatic void put_ws();
		repeat ($urandom_range(0, 2))
			put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endfunction

	function automatic void put_eol();
		case ($urandom_range(0, 2))
			0: put_byte(CH_LF);
			1: put_byte(CH_CR);
			default: begin
				put_byte(CH_CR);
				put_byte(CH_LF);
			end
		endcase
	endfunction

	// Aim 0 gives a random name, 1 the wanted name, a close miss or a random name, 2 the wanted name.
	function automatic void put_name(bit is_key, int aim);
		logic [63:0] nm;
		int n;
		int pos;
		logic [7:0] q[$];
		nm = is_key ? key_name : sec_name;
		n = is_key ? key_n : sec_n;
		if (n > 8)
			n = 8;
		for (int i = 0; i < n; i++)
			q.push_back(nm[8*i +: 8]);
		if (aim == 0) begin
			q.delete();
			repeat ($urandom_range(0, 11))
				q.push_back(name_char());
		end else if (aim == 1) begin
			case ($urandom_range(0, 9))
				6: begin
					if (q.size() > 0)
						void'(q.pop_back());
				end
				7: begin
					repeat ($urandom_range(1, 4))
						q.push_back(name_char());
				end
				8: begin
					if (q.size() > 0) begin
						pos = $urandom_range(0, q.size() - 1);
						q[pos] = q[pos] ^ 8'h01;
					end
				end
				9: begin
					q.delete();
					repeat ($urandom_range(0, 11))
						q.push_back(name_char());
				end
				default: begin
				end
			endcase
		end
		foreach (q[i])
			put_byte(q[i]);
	endfunction

	function automatic void put_header(int aim);
		put_ws();
		put_byte(CH_LBRK);
		put_name(1'b0, aim);
		if ($urandom_range(0, 7) != 0)
			put_byte(CH_RBRK);
		if ($urandom_range(0, 5) == 0)
			put_byte(text_char());
		put_eol();
	endfunction

	function automatic void put_key(int aim);
		int vlen;
		vlen = ($urandom_range(0, 59) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 10);
		put_ws();
		put_name(1'b1, aim);
		if ($urandom_range(0, 9) != 0) begin
			put_byte(CH_EQ);
			repeat (vlen)
				put_byte(text_char());
		end
		put_eol();
	endfunction

	function automatic void put_line();
		case ($urandom_range(0, 11))
			0: begin
				put_ws();
				put_eol();
			end
			1: begin
				put_ws();
				put_byte($urandom_range(0, 1) ? CH_SEMI : CH_HASH);
				repeat ($urandom_range(0, 6))
					put_byte(text_char());
				put_eol();
			end
			2: put_header($urandom_range(0, 1));
			3: begin
				repeat ($urandom_range(1, 6))
					put_byte(8'($urandom_range(0, 255)));
			end
			default: put_key(($urandom_range(0, 2) == 0) ? 0 : 1);
		endcase
	endfunction

	function automatic void put_ini();
		repeat ($urandom_range(0, 2))
			put_line();
		if ($urandom_range(0, 3) != 0)
			put_header(1);
		repeat ($urandom_range(1, 6))
			put_line();
		case ($urandom_range(0, 4))
			2: begin
				put_ws();
				put_name(1'b1, 1);
				put_byte(CH_EQ);
				repeat ($urandom_range(0, 4))
					put_byte(text_char());
			end
			3: begin
				put_byte(CH_NUL);
				repeat ($urandom_range(0, 3))
					put_byte(text_char());
			end
			4: put_byte(CH_NUL);
			default: begin
			end
		endcase
		if (words.size() == 0)
			put_byte(text_char());
		close_text();
	endfunction

	task automatic send_words(bit gaps_on);
		int burst;
		burst = $urandom_range(1, 24);
		foreach (words[i]) begin
			if (gaps_on && burst == 0) begin
				repeat ($urandom_range(1, 5)) begin
					@(negedge clk);
					text_ch.valid <= 1'b0;
				end
				burst = $urandom_range(1, 24);
			end
			@(negedge clk);
			text_ch.valid <= 1'b1;
			text_ch.text_byte <= words[i].ch;
			text_ch.end_of_text <= words[i].eot;
			@(posedge clk);
			while (!text_ch.ready)
				@(posedge clk);
			burst--;
			items_sent++;
		end
		@(negedge clk);
		text_ch.valid <= 1'b0;
		words.delete();
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_config(logic [63:0] sn, logic [3:0] sl, logic [63:0] kn, logic [3:0] kl);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SECTION_NAME;
		cfg_data <= sn;
		@(negedge clk);
		cfg_index <= REG_SECTION_LEN;
		cfg_data <= {60'd0, sl};
		@(negedge clk);
		cfg_index <= REG_KEY_NAME;
		cfg_data <= kn;
		@(negedge clk);
		cfg_index <= REG_KEY_LEN;
		cfg_data <= {60'd0, kl};
		@(negedge clk);
		cfg_we <= 1'b0;
		sec_name = sn;
		sec_n = sl;
		key_name = kn;
		key_n = kl;
	endtask

	function automatic int pick_len(bit plain);
		if (plain)
			return $urandom_range(1, 8);
		case ($urandom_range(0, 11))
			0: return 0;
			1, 2: return 8;
			3: return $urandom_range(9, 15);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	task automatic new_config(bit plain);
		logic [63:0] sn;
		logic [63:0] kn;
		int sl;
		int kl;
		sl = pick_len(plain);
		kl = pick_len(plain);
		sn = {$urandom(), $urandom()};
		kn = {$urandom(), $urandom()};
		if ($urandom_range(0, 5) == 0)
			sn = '1;
		if ($urandom_range(0, 5) == 0)
			kn = '1;
		for (int i = 0; i < sl && i < 8; i++)
			sn[8*i +: 8] = name_char();
		for (int i = 0; i < kl && i < 8; i++)
			kn[8*i +: 8] = name_char();
		write_config(sn, 4'(sl), kn, 4'(kl));
	endtask

	initial begin
		int guard;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SECTION_NAME;
		cfg_data <= '0;
		text_ch.valid <= 1'b0;
		text_ch.text_byte <= 8'h00;
		text_ch.end_of_text <= 1'b0;
		sec_name = '0;
		key_name = '0;
		sec_n = 0;
		key_n = 0;
		items_sent = 0;
		hold_results = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// With the reset settings both names are empty, so "[]" and a bare "=" match.
		put_text("[]\n=");
		put_byte(8'hFF);
		put_byte(8'h80);
		close_text();
		send_words(1'b1);
		wait_idle();

		write_config(64'hFFFF_FFFF_FFFF_FF73, 4'd1, 64'h0123_4567_89AB_CD6B, 4'd1);
		put_text(" \t#\n[s\n[s]\nk\nk=");
		put_byte(CH_NUL);
		put_text("!");
		close_text();
		put_text("[s]\n[t]");
		close_text();
		send_words(1'b0);
		wait_idle();

		// A long value against a receiver that holds off fills the result queue
		// and runs into the value length limit.
		new_config(1'b1);
		put_byte(CH_LBRK);
		put_name(1'b0, 2);
		put_byte(CH_RBRK);
		put_eol();
		put_name(1'b1, 2);
		put_byte(CH_EQ);
		repeat (300)
			put_byte(text_char());
		put_eol();
		close_text();
		@(posedge clk);
		hold_results = 1'b1;
		send_words(1'b0);

		while (items_sent < ITEM_GOAL) begin
			wait_idle();
			new_config(1'b0);
			repeat ($urandom_range(1, 3))
				put_ini();
			if ($urandom_range(0, 9) == 0) begin
				@(posedge clk);
				hold_results = 1'b1;
			end
			send_words($urandom_range(0, 3) != 0);
		end

		guard = 0;
		do begin
			@(negedge clk);
			guard++;
		end while (pending != 0 && guard < 100000);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
